>>> rtl/core/wcsc_pkg.sv
// Shared types, constants and lookup tables for the word clock set controller.
// No dependencies; every other file in rtl/core refers to this package by scoped names.
package wcsc_pkg;

    localparam int LED_COUNT   = 36;
    localparam int COUNT_WIDTH = 16;
    localparam int CFG_WIDTH   = 16;

    typedef logic [COUNT_WIDTH-1:0] cnt_t;
    typedef logic [CFG_WIDTH-1:0]   cfg_word_t;
    typedef logic [LED_COUNT-1:0]   led_mask_t;
    typedef logic [5:0]             led_idx_t;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_HOUR   = 2'd1,
        MODE_MINUTE = 2'd2
    } mode_t;

    // register indexes (byte address / 4)
    localparam logic [1:0] REG_DEBOUNCE   = 2'd0;
    localparam logic [1:0] REG_LONG_PRESS = 2'd1;
    localparam logic [1:0] REG_BLINK      = 2'd2;

    localparam cfg_word_t DEBOUNCE_RESET   = 16'd50;
    localparam cfg_word_t LONG_PRESS_RESET = 16'd1000;
    localparam cfg_word_t BLINK_RESET      = 16'd300;

    localparam logic [7:0] BRIGHT_MIN  = 8'd30;
    localparam logic [7:0] BRIGHT_STEP = 8'd30;
    localparam logic [7:0] BRIGHT_MAX  = 8'd240;

    localparam logic [4:0] HOUR_LAST   = 5'd23;
    localparam logic [5:0] MINUTE_LAST = 6'd59;

    localparam led_idx_t LED_HOUR_MARK   = 6'd23;
    localparam led_idx_t LED_MINUTE_MARK = 6'd0;
    localparam led_idx_t LED_TEN_WORD    = 6'd12;
    localparam led_idx_t LED_MIDNIGHT    = 6'd17;
    localparam led_idx_t LED_NOON        = 6'd5;
    localparam led_idx_t LED_NOON_SHARED = 6'd6;

    typedef struct packed {
        cfg_word_t debounce_ticks;
        cfg_word_t long_press_ticks;
        cfg_word_t blink_ticks;
    } cfg_t;

    // accepted-level change of one debounced button
    typedef struct packed {
        logic fire;
        logic level;
    } btn_evt_t;

    // post-tick view of the set-mode state
    typedef struct packed {
        mode_t      mode;
        logic [4:0] hour_offset;
        logic [5:0] minute_offset;
        logic       hour_blink;
        logic       minute_blink;
    } ts_status_t;

    function automatic logic cnt_gt_cfg(cnt_t c, cfg_word_t v);
        return {{(33-COUNT_WIDTH){1'b0}}, c} > {{(33-CFG_WIDTH){1'b0}}, v};
    endfunction

    function automatic logic cnt_ge_cfg(cnt_t c, cfg_word_t v);
        return {{(33-COUNT_WIDTH){1'b0}}, c} >= {{(33-CFG_WIDTH){1'b0}}, v};
    endfunction

    function automatic led_idx_t hour_led_a(logic [3:0] h);
        led_idx_t r;
        case (h)
            4'd0:    r = 6'd20;
            4'd1:    r = 6'd30;
            4'd2:    r = 6'd31;
            4'd3:    r = 6'd32;
            4'd4:    r = 6'd33;
            4'd5:    r = 6'd34;
            4'd6:    r = 6'd29;
            4'd7:    r = 6'd27;
            4'd8:    r = 6'd25;
            4'd9:    r = 6'd18;
            4'd10:   r = 6'd20;
            4'd11:   r = 6'd20;
            default: r = 6'd20;
        endcase
        return r;
    endfunction

    // zero means no second word
    function automatic led_idx_t hour_led_b(logic [3:0] h);
        led_idx_t r;
        case (h)
            4'd0:    r = 6'd22;
            4'd5:    r = 6'd35;
            4'd6:    r = 6'd28;
            4'd7:    r = 6'd26;
            4'd8:    r = 6'd24;
            4'd9:    r = 6'd19;
            4'd11:   r = 6'd21;
            default: r = 6'd0;
        endcase
        return r;
    endfunction

    function automatic led_idx_t tens_led(logic [2:0] t);
        led_idx_t r;
        case (t)
            3'd2:    r = 6'd16;
            3'd3:    r = 6'd15;
            3'd4:    r = 6'd14;
            3'd5:    r = 6'd13;
            default: r = 6'd0;
        endcase
        return r;
    endfunction

    function automatic led_idx_t unit_led(logic [3:0] u);
        led_idx_t r;
        case (u)
            4'd1:    r = 6'd7;
            4'd2:    r = 6'd4;
            4'd3:    r = 6'd8;
            4'd4:    r = 6'd3;
            4'd5:    r = 6'd9;
            4'd6:    r = 6'd2;
            4'd7:    r = 6'd10;
            4'd8:    r = 6'd1;
            4'd9:    r = 6'd11;
            default: r = 6'd0;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/core/wcsc_debounce.sv
// Debouncer for one active-low button; reports the tick at which a new level is accepted.
// Depends on wcsc_pkg.
module wcsc_debounce (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  raw,
    input  wcsc_pkg::cfg_word_t   debounce_ticks,
    output wcsc_pkg::btn_evt_t    evt
);

    logic               prev_reg;
    logic               stable_reg;
    wcsc_pkg::cnt_t     cnt_reg;
    wcsc_pkg::cnt_t     cnt_next;

    always_comb begin
        if (raw != prev_reg) begin
            cnt_next = '0;
        end else if (cnt_reg == '1) begin
            cnt_next = cnt_reg;
        end else begin
            cnt_next = cnt_reg + 1'b1;
        end
        evt.fire  = wcsc_pkg::cnt_gt_cfg(cnt_next, debounce_ticks) && (raw != stable_reg);
        evt.level = raw;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg   <= 1'b1;
            stable_reg <= 1'b1;
            cnt_reg    <= '0;
        end else if (en) begin
            prev_reg <= raw;
            cnt_reg  <= cnt_next;
            if (evt.fire) begin
                stable_reg <= raw;
            end
        end
    end

    a_fire_takes_level: assert property (@(posedge aclk) disable iff (!aresetn)
        en && evt.fire |=> stable_reg == $past(raw))
        else $error("accepted level not stored");

endmodule

>>> rtl/core/wcsc_time_set.sv
// Press timing, mode stepping, hour/minute offsets and marker blink counters.
// Depends on wcsc_pkg; fed by the time button debouncer.
module wcsc_time_set (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  wcsc_pkg::btn_evt_t    time_evt,
    input  wcsc_pkg::cfg_t        cfg,
    output wcsc_pkg::ts_status_t  status
);

    wcsc_pkg::cnt_t       age_reg, age_next, age_inc;
    logic                 pending_reg, pending_next;
    wcsc_pkg::mode_t      mode_reg, mode_next;
    logic [4:0]           hour_off_reg, hour_off_next;
    logic [5:0]           min_off_reg, min_off_next;
    wcsc_pkg::cfg_word_t  hour_blink_reg, hour_blink_next;
    wcsc_pkg::cfg_word_t  min_blink_reg, min_blink_next;
    logic                 press, release_hit, short_release, long_hit;

    always_comb begin
        age_inc     = (age_reg == '1) ? age_reg : age_reg + 1'b1;
        press       = time_evt.fire && !time_evt.level;
        release_hit = time_evt.fire && time_evt.level;
        short_release = release_hit && !wcsc_pkg::cnt_ge_cfg(age_inc, cfg.long_press_ticks);

        hour_blink_next = (hour_blink_reg != '0) ? hour_blink_reg - 1'b1 : hour_blink_reg;
        min_blink_next  = (min_blink_reg != '0) ? min_blink_reg - 1'b1 : min_blink_reg;

        age_next      = press ? '0 : age_inc;
        pending_next  = pending_reg;
        hour_off_next = hour_off_reg;
        min_off_next  = min_off_reg;
        if (press) begin
            pending_next = 1'b1;
        end else if (short_release) begin
            pending_next = 1'b0;
            if (mode_reg == wcsc_pkg::MODE_HOUR) begin
                hour_off_next = (hour_off_reg >= wcsc_pkg::HOUR_LAST) ? 5'd0
                                                                      : hour_off_reg + 5'd1;
            end else if (mode_reg == wcsc_pkg::MODE_MINUTE) begin
                min_off_next = (min_off_reg >= wcsc_pkg::MINUTE_LAST) ? 6'd0
                                                                      : min_off_reg + 6'd1;
            end
        end

        long_hit  = pending_next && wcsc_pkg::cnt_ge_cfg(age_next, cfg.long_press_ticks);
        mode_next = mode_reg;
        if (long_hit) begin
            pending_next = 1'b0;
            case (mode_reg)
                wcsc_pkg::MODE_NORMAL: begin
                    mode_next       = wcsc_pkg::MODE_HOUR;
                    hour_blink_next = cfg.blink_ticks;
                end
                wcsc_pkg::MODE_HOUR: begin
                    mode_next      = wcsc_pkg::MODE_MINUTE;
                    min_blink_next = cfg.blink_ticks;
                end
                default: begin
                    mode_next = wcsc_pkg::MODE_NORMAL;
                end
            endcase
        end

        status.mode          = mode_next;
        status.hour_offset   = hour_off_next;
        status.minute_offset = min_off_next;
        status.hour_blink    = (hour_blink_next != '0);
        status.minute_blink  = (min_blink_next != '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            age_reg        <= '0;
            pending_reg    <= 1'b0;
            mode_reg       <= wcsc_pkg::MODE_NORMAL;
            hour_off_reg   <= '0;
            min_off_reg    <= '0;
            hour_blink_reg <= '0;
            min_blink_reg  <= '0;
        end else if (en) begin
            age_reg        <= age_next;
            pending_reg    <= pending_next;
            mode_reg       <= mode_next;
            hour_off_reg   <= hour_off_next;
            min_off_reg    <= min_off_next;
            hour_blink_reg <= hour_blink_next;
            min_blink_reg  <= min_blink_next;
        end
    end

    a_hour_off_range: assert property (@(posedge aclk) disable iff (!aresetn)
        hour_off_reg <= wcsc_pkg::HOUR_LAST)
        else $error("hour offset out of range");

    a_min_off_range: assert property (@(posedge aclk) disable iff (!aresetn)
        min_off_reg <= wcsc_pkg::MINUTE_LAST)
        else $error("minute offset out of range");

    a_long_clears_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        en && long_hit |=> !pending_reg)
        else $error("pending press survived a mode step");

endmodule

>>> rtl/core/wcsc_display.sv
// Shown time (clock plus offsets, wrapped) and the 36-LED word mask with marker blink.
// Depends on wcsc_pkg for the LED tables; purely combinational.
module wcsc_display (
    input  logic [4:0]            rtc_hour,
    input  logic [5:0]            rtc_minute,
    input  wcsc_pkg::ts_status_t  status,
    output logic [4:0]            shown_hour,
    output logic [5:0]            shown_minute,
    output wcsc_pkg::led_mask_t   led_mask
);

    logic [5:0]          hsum;
    logic [6:0]          msum;
    logic [3:0]          h12;
    logic [2:0]          tens;
    logic [5:0]          units_full;
    logic [3:0]          units;
    wcsc_pkg::led_idx_t  hb;
    wcsc_pkg::led_mask_t mask;
    wcsc_pkg::led_mask_t one;

    always_comb begin
        one  = wcsc_pkg::led_mask_t'(1);
        hsum = {1'b0, rtc_hour} + {1'b0, status.hour_offset};
        if (hsum >= 6'd48) begin
            shown_hour = 5'(hsum - 6'd48);
        end else if (hsum >= 6'd24) begin
            shown_hour = 5'(hsum - 6'd24);
        end else begin
            shown_hour = hsum[4:0];
        end

        msum = {1'b0, rtc_minute} + {1'b0, status.minute_offset};
        if (msum >= 7'd120) begin
            shown_minute = 6'(msum - 7'd120);
        end else if (msum >= 7'd60) begin
            shown_minute = 6'(msum - 7'd60);
        end else begin
            shown_minute = msum[5:0];
        end

        h12 = (shown_hour >= 5'd12) ? 4'(shown_hour - 5'd12) : shown_hour[3:0];
        if (shown_minute >= 6'd50)      tens = 3'd5;
        else if (shown_minute >= 6'd40) tens = 3'd4;
        else if (shown_minute >= 6'd30) tens = 3'd3;
        else if (shown_minute >= 6'd20) tens = 3'd2;
        else if (shown_minute >= 6'd10) tens = 3'd1;
        else                            tens = 3'd0;
        units_full = shown_minute - ({tens, 3'b000} + {2'b00, tens, 1'b0});
        units      = units_full[3:0];
        hb         = wcsc_pkg::hour_led_b(h12);

        if (shown_minute == 6'd0 && shown_hour == 5'd0) begin
            mask = (one << wcsc_pkg::LED_MIDNIGHT) | (one << wcsc_pkg::LED_NOON_SHARED);
        end else if (shown_minute == 6'd0 && shown_hour == 5'd12) begin
            mask = (one << wcsc_pkg::LED_NOON_SHARED) | (one << wcsc_pkg::LED_NOON);
        end else begin
            mask = (one << wcsc_pkg::LED_HOUR_MARK) | (one << wcsc_pkg::hour_led_a(h12));
            if (hb != '0)            mask = mask | (one << hb);
            if (shown_minute != '0)  mask = mask | (one << wcsc_pkg::LED_MINUTE_MARK);
            if (tens != 3'd0)        mask = mask | (one << wcsc_pkg::LED_TEN_WORD);
            if (tens >= 3'd2)        mask = mask | (one << wcsc_pkg::tens_led(tens));
            if (units != 4'd0)       mask = mask | (one << wcsc_pkg::unit_led(units));
        end

        if (status.hour_blink)   mask = mask ^ (one << wcsc_pkg::LED_HOUR_MARK);
        if (status.minute_blink) mask = mask ^ (one << wcsc_pkg::LED_MINUTE_MARK);
        led_mask = mask;
    end

endmodule

>>> rtl/core/word_clock_set_controller_unit.sv
// Top level of the word clock set controller: input register, tick logic, result register.
// Depends on wcsc_pkg, wcsc_debounce, wcsc_time_set and wcsc_display.

// Each request on the s_ channel is one millisecond tick carrying the raw (active-low)
// time and LED button levels and the real-time clock's hour and minute. Each tick yields
// exactly one request on the m_ channel: the 36-bit word LED mask, the brightness, the
// set mode and the shown hour and minute. The block takes one tick per clock cycle
// while m_tready is high. An accepted tick lands in an input register; the debounce,
// press-timing and display logic runs on it once the result register is free or being
// drained, and its outcome is stored in the result register. A result waiting in that
// register stalls the input only once the input register also holds a tick; with
// m_tready held high a tick is taken every cycle. Debounce, long-press and blink
// lengths are set through the APB port (debounce_ticks at 0x0, long_press_ticks at 0x4,
// blink_ticks at 0x8, low 16 bits used); write them only while no tick is in flight.
module word_clock_set_controller_unit (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    // [0] time_button_raw, [1] led_button_raw, [6:2] rtc_hour, [12:7] rtc_minute, zero pad
    input  logic [15:0] s_tdata,

    output logic        m_tvalid,
    input  logic        m_tready,
    // [35:0] led_mask, [43:36] brightness, [45:44] set_mode, [50:46] shown_hour,
    // [56:51] shown_minute, zero pad
    output logic [63:0] m_tdata,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // configuration registers
    wcsc_pkg::cfg_t       cfg_reg;
    logic                 cfg_wr;

    // input stage
    logic                 in_valid_reg;
    logic                 time_raw_reg;
    logic                 led_raw_reg;
    logic [4:0]           hour_in_reg;
    logic [5:0]           minute_in_reg;

    // result stage
    logic                 out_valid_reg;
    logic [63:0]          out_data_reg;

    logic                 advance;
    logic [7:0]           bright_reg;
    logic [7:0]           bright_next;

    wcsc_pkg::btn_evt_t   time_evt;
    wcsc_pkg::btn_evt_t   led_evt;
    wcsc_pkg::ts_status_t status;
    logic [4:0]           shown_hour;
    logic [5:0]           shown_minute;
    wcsc_pkg::led_mask_t  led_mask;

    // ---------------------------------------------------------------- APB
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        case (paddr[3:2])
            wcsc_pkg::REG_DEBOUNCE:   prdata = {16'd0, cfg_reg.debounce_ticks};
            wcsc_pkg::REG_LONG_PRESS: prdata = {16'd0, cfg_reg.long_press_ticks};
            wcsc_pkg::REG_BLINK:      prdata = {16'd0, cfg_reg.blink_ticks};
            default:                  prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ticks   <= wcsc_pkg::DEBOUNCE_RESET;
            cfg_reg.long_press_ticks <= wcsc_pkg::LONG_PRESS_RESET;
            cfg_reg.blink_ticks      <= wcsc_pkg::BLINK_RESET;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                wcsc_pkg::REG_DEBOUNCE:   cfg_reg.debounce_ticks   <= pwdata[15:0];
                wcsc_pkg::REG_LONG_PRESS: cfg_reg.long_press_ticks <= pwdata[15:0];
                wcsc_pkg::REG_BLINK:      cfg_reg.blink_ticks      <= pwdata[15:0];
                default: ;  // unmapped address: write dropped
            endcase
        end
    end

    // ---------------------------------------------------------------- pipeline
    // the tick in the input register is processed when the result slot is free or
    // being drained this cycle; all state updates happen on that same edge
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            time_raw_reg  <= s_tdata[0];
            led_raw_reg   <= s_tdata[1];
            hour_in_reg   <= s_tdata[6:2];
            minute_in_reg <= s_tdata[12:7];
        end
    end

    // ---------------------------------------------------------------- buttons
    wcsc_debounce u_time_db (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .en             (advance),
        .raw            (time_raw_reg),
        .debounce_ticks (cfg_reg.debounce_ticks),
        .evt            (time_evt)
    );

    wcsc_debounce u_led_db (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .en             (advance),
        .raw            (led_raw_reg),
        .debounce_ticks (cfg_reg.debounce_ticks),
        .evt            (led_evt)
    );

    wcsc_time_set u_time_set (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (advance),
        .time_evt (time_evt),
        .cfg      (cfg_reg),
        .status   (status)
    );

    // brightness steps on LED button release, wrapping from top back to bottom
    always_comb begin
        bright_next = bright_reg;
        if (led_evt.fire && led_evt.level) begin
            bright_next = (bright_reg >= wcsc_pkg::BRIGHT_MAX) ? wcsc_pkg::BRIGHT_MIN
                                                               : bright_reg + wcsc_pkg::BRIGHT_STEP;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bright_reg <= wcsc_pkg::BRIGHT_MIN;
        end else if (advance) begin
            bright_reg <= bright_next;
        end
    end

    // ---------------------------------------------------------------- display
    wcsc_display u_display (
        .rtc_hour     (hour_in_reg),
        .rtc_minute   (minute_in_reg),
        .status       (status),
        .shown_hour   (shown_hour),
        .shown_minute (shown_minute),
        .led_mask     (led_mask)
    );

    // ---------------------------------------------------------------- result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {7'd0, shown_minute, shown_hour, status.mode, bright_next,
                             led_mask};
        end
    end

    a_bright_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bright_reg >= wcsc_pkg::BRIGHT_MIN && bright_reg <= wcsc_pkg::BRIGHT_MAX)
        else $error("brightness out of range");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_tready)
        else $error("input stalled with empty result slot");

    a_result_follows_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("processed tick produced no result");

endmodule
